// ===== sv/pib_pkg.sv =====
// Package for the bound-push pipeline: payload structs, register codes,
// widths and saturating helpers. It depends on nothing else.
package pib_pkg;

  localparam int unsigned DataW  = 64;
  localparam int unsigned FracW  = 33;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned ProdW  = DataW - 1;

  localparam logic [FracW-1:0] FracReset = 33'd42949673;

  localparam logic signed [DataW-1:0] SMax = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] SMin = {1'b1, {(DataW-1){1'b0}}};

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PUSH_FRACTION = 8'd0,
    CFG_GAP_FRACTION  = 8'd1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic signed [DataW-1:0] lower_bound;
    logic                    has_lower;
    logic signed [DataW-1:0] upper_bound;
    logic                    has_upper;
    logic                    last_in;
  } in_t;

  typedef struct packed {
    logic signed [DataW-1:0] projected;
    logic                    infeasible;
    logic                    last_out;
  } out_t;

  typedef struct packed {
    logic signed [DataW-1:0] x;
    logic signed [DataW-1:0] lo;
    logic signed [DataW-1:0] up;
    logic                    hl;
    logic                    hu;
    logic                    last;
    logic                    crossed;
  } ctx_t;

  function automatic logic signed [DataW-1:0] sat_wide(input logic signed [DataW:0] s);
    logic signed [DataW-1:0] r;
    if (s[DataW] != s[DataW-1]) begin
      r = s[DataW] ? SMin : SMax;
    end else begin
      r = s[DataW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [DataW-1:0] sat_add(input logic signed [DataW-1:0] a,
                                                      input logic signed [DataW-1:0] b);
    logic signed [DataW:0] s;
    s = {a[DataW-1], a} + {b[DataW-1], b};
    return sat_wide(s);
  endfunction

  function automatic logic signed [DataW-1:0] sat_sub(input logic signed [DataW-1:0] a,
                                                      input logic signed [DataW-1:0] b);
    logic signed [DataW:0] s;
    s = {a[DataW-1], a} - {b[DataW-1], b};
    return sat_wide(s);
  endfunction

  // Magnitude of a bound, never below one in Q32.32.
  function automatic logic [DataW-1:0] mag_floor_one(input logic signed [DataW-1:0] b);
    logic [DataW-1:0] m;
    m = b[DataW-1] ? (DataW'(0) - DataW'(b)) : DataW'(b);
    if (m[DataW-1:DataW/2] == '0) begin
      m = {{(DataW/2-1){1'b0}}, 1'b1, {(DataW/2){1'b0}}};
    end
    return m;
  endfunction

endpackage

// ===== sv/project_into_bounds.sv =====
// Throughput: one transaction per cycle; the six stages move together, so the
// pipeline holds whenever the output register is full and out_ready_i is low.
// Reset clears all valid bits and loads both fractions with about 0.01.
// Top level of the bound-push pipeline. Depends on pib_pkg and pib_mul_frac.
module project_into_bounds import pib_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_t               out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DataW-1:0]   cfg_data_i
);

  logic             adv;
  logic [FracW-1:0] push_q, gap_q;

  logic             v1_q, v2_q, v3_q, v4_q, v5_q, vo_q;
  ctx_t             c1_d, c1_q, c2_q, c3_q, c4_q, c5_q;
  logic [DataW-1:0] diff1_q, magl1_q, magu1_q;
  logic [ProdW-1:0] mg3, ml3, mu3;

  logic signed [DataW-1:0] gap4, ml_ext, mu_ext, ml4_d, mu4_d, ml4_q, mu4_q;
  logic signed [DataW-1:0] tlo5_q, tup5_q;
  out_t                    out_d, out_q;

  assign adv         = !vo_q || out_ready_i;
  assign in_ready_o  = adv;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push_q <= FracReset;
      gap_q  <= FracReset;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_PUSH_FRACTION: push_q <= cfg_data_i[FracW-1:0];
        CFG_GAP_FRACTION:  gap_q  <= cfg_data_i[FracW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      vo_q <= v5_q;
    end
  end

  always_comb begin
    c1_d.x       = in_data_i.value;
    c1_d.lo      = in_data_i.lower_bound;
    c1_d.up      = in_data_i.upper_bound;
    c1_d.hl      = in_data_i.has_lower;
    c1_d.hu      = in_data_i.has_upper;
    c1_d.last    = in_data_i.last_in;
    c1_d.crossed = in_data_i.lower_bound > in_data_i.upper_bound;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c1_q    <= c1_d;
      diff1_q <= DataW'(sat_sub(in_data_i.upper_bound, in_data_i.lower_bound));
      magl1_q <= mag_floor_one(in_data_i.lower_bound);
      magu1_q <= mag_floor_one(in_data_i.upper_bound);
      c2_q    <= c1_q;
      c3_q    <= c2_q;
    end
  end

  pib_mul_frac u_mul_gap (
    .clk_i (clk_i),
    .en_i  (adv),
    .a_i   (diff1_q),
    .k_i   (gap_q),
    .p_o   (mg3)
  );

  pib_mul_frac u_mul_lo (
    .clk_i (clk_i),
    .en_i  (adv),
    .a_i   (magl1_q),
    .k_i   (push_q),
    .p_o   (ml3)
  );

  pib_mul_frac u_mul_up (
    .clk_i (clk_i),
    .en_i  (adv),
    .a_i   (magu1_q),
    .k_i   (push_q),
    .p_o   (mu3)
  );

  always_comb begin
    gap4   = signed'({1'b0, mg3}) - 64'sd1;
    ml_ext = signed'({1'b0, ml3});
    mu_ext = signed'({1'b0, mu3});
    if (c3_q.hl && c3_q.hu) begin
      ml4_d = (ml_ext > gap4) ? gap4 : ml_ext;
      mu4_d = (mu_ext > gap4) ? gap4 : mu_ext;
    end else begin
      ml4_d = ml_ext - 64'sd1;
      mu4_d = mu_ext - 64'sd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c4_q   <= c3_q;
      ml4_q  <= ml4_d;
      mu4_q  <= mu4_d;
      c5_q   <= c4_q;
      tlo5_q <= sat_add(c4_q.lo, ml4_q);
      tup5_q <= sat_sub(c4_q.up, mu4_q);
    end
  end

  always_comb begin
    out_d.projected  = c5_q.x;
    out_d.infeasible = c5_q.hl && c5_q.hu && c5_q.crossed;
    out_d.last_out   = c5_q.last;
    if (c5_q.hl && c5_q.hu) begin
      if (!c5_q.crossed) begin
        if (c5_q.x < tlo5_q) begin
          out_d.projected = tlo5_q;
        end else if (c5_q.x > tup5_q) begin
          out_d.projected = tup5_q;
        end
      end
    end else if (c5_q.hl) begin
      if (c5_q.x < tlo5_q) begin
        out_d.projected = tlo5_q;
      end
    end else if (c5_q.hu) begin
      if (c5_q.x > tup5_q) begin
        out_d.projected = tup5_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = vo_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/pib_mul_frac.sv =====
// Two-stage fractional multiplier: floor(a * k / 2^32), capped at the
// largest signed 64-bit value. Depends on pib_pkg.
module pib_mul_frac import pib_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [DataW-1:0] a_i,
  input  logic [FracW-1:0] k_i,
  output logic [ProdW-1:0] p_o
);

  localparam int unsigned HalfW = DataW / 2;
  localparam int unsigned SumW  = DataW + FracW;

  logic [DataW-1:0] pl_q, ph_q;
  logic [HalfW-1:0] al_k_q, ah_k_q;
  logic [SumW-1:0]  sum;
  logic [ProdW-1:0] p_d, p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q   <= a_i[HalfW-1:0] * k_i[HalfW-1:0];
      ph_q   <= a_i[DataW-1:HalfW] * k_i[HalfW-1:0];
      al_k_q <= k_i[FracW-1] ? a_i[HalfW-1:0] : '0;
      ah_k_q <= k_i[FracW-1] ? a_i[DataW-1:HalfW] : '0;
    end
  end

  always_comb begin
    sum = SumW'(pl_q[DataW-1:HalfW]) + SumW'(ph_q) + SumW'(al_k_q)
        + SumW'({ah_k_q, {HalfW{1'b0}}});
    if (sum[SumW-1:ProdW] != '0) begin
      p_d = '1;
    end else begin
      p_d = sum[ProdW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

// ===== sv/pib_checker.sv =====
// Port-level checker for project_into_bounds and the bind that attaches it.
// Depends on pib_pkg.
module pib_checker import pib_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input in_t                in_data_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input out_t               out_data_o,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic [CfgIdxW-1:0] cfg_index_i,
  input logic [DataW-1:0]   cfg_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("A pending result transaction was dropped.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("A pending result transaction changed.");

  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("Input ready does not follow the output stall.");

  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("A result transaction appeared right after reset.");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("A configuration transaction was refused.");

endmodule

bind project_into_bounds pib_checker u_pib_checker (.*);
